// File: design/biu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biu_pkg
// Shared constants, types and helpers of the bicubic upscaler.
// ---------------------------------------------------------------------------
package biu_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_SCALE_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } biu_state_t;

  // Catmull-Rom fraction sub/scale in Q0.16, half rounded up; small table.
  // Power-of-two scales are exact shifts, the others are tabulated.
  function automatic logic [16:0] frac_q16(input logic [3:0] sub, input logic [3:0] s);
    logic [16:0] r;
    begin
      r = '0;
      unique case (s)
        4'd2: r = 17'({sub, 16'b0} >> 1);
        4'd3: begin
          unique case (sub)
            4'd1: r = 17'd21845;
            4'd2: r = 17'd43691;
            default: r = '0;
          endcase
        end
        4'd4: r = 17'({sub, 16'b0} >> 2);
        4'd5: begin
          unique case (sub)
            4'd1: r = 17'd13107;
            4'd2: r = 17'd26214;
            4'd3: r = 17'd39322;
            4'd4: r = 17'd52429;
            default: r = '0;
          endcase
        end
        4'd6: begin
          unique case (sub)
            4'd1: r = 17'd10923;
            4'd2: r = 17'd21845;
            4'd3: r = 17'd32768;
            4'd4: r = 17'd43691;
            4'd5: r = 17'd54613;
            default: r = '0;
          endcase
        end
        4'd7: begin
          unique case (sub)
            4'd1: r = 17'd9362;
            4'd2: r = 17'd18725;
            4'd3: r = 17'd28087;
            4'd4: r = 17'd37449;
            4'd5: r = 17'd46811;
            4'd6: r = 17'd56174;
            default: r = '0;
          endcase
        end
        4'd8: r = 17'({sub, 16'b0} >> 3);
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: design/biu_cubic.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biu_cubic
// Sequenced Catmull-Rom evaluator: 15 cubics per channel set, one
// multiply per cycle, registered between steps.
// ---------------------------------------------------------------------------
module biu_cubic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [16*24-1:0]   win,
  input  logic [16:0]        tcol,
  input  logic [16:0]        trow,
  output logic               done,
  output logic [23:0]        pix
);
  import biu_pkg::*;

  // step counter: cubic index (0..11 column cubics over 3 channels x 4 rows,
  // 12..14 row cubics), phase 0..3 within a cubic.
  logic        busy;
  logic [3:0]  cidx;
  logic [1:0]  ph;
  logic signed [31:0] a, b, c, p0, p1, p2, p3, res;
  logic signed [31:0] rowv [12];
  logic signed [49:0] prod;
  logic signed [31:0] mop;
  logic [16:0] t;
  logic [1:0]  ch;
  logic [1:0]  ln;
  logic signed [31:0] q [4];

  assign ch = (cidx < 4'd12) ? 2'(cidx >> 2) : 2'(cidx - 4'd12);
  assign ln = cidx[1:0];
  assign t  = (cidx < 4'd12) ? tcol : trow;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (cidx < 4'd12) begin
        q[k] = {8'd0, win[(ln*4+k)*24 + ch*8 +: 8], 16'd0};
      end else begin
        q[k] = rowv[ch*4 + k];
      end
    end
  end

  always_comb begin
    unique case (ph)
      2'd1: mop = a;
      2'd2: mop = b;
      default: mop = c;
    endcase
    prod = $signed({1'b0, t}) * mop;
  end

  assign res = p1 + 32'(prod >>> 17);

  function automatic logic [7:0] clamp8(input logic signed [31:0] v);
    begin
      if (v <= 0) return 8'd0;
      if ((v >>> 16) > 255) return 8'd255;
      return v[23:16];
    end
  endfunction

  // done pulses in the cycle after the last phase of the last row cubic
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy && !start && (ph == 2'd3) && (cidx == 4'd14);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cidx <= '0;
      ph   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cidx <= '0;
      ph   <= '0;
    end else if (busy) begin
      unique case (ph)
        2'd0: begin
          p0 <= q[0]; p1 <= q[1]; p2 <= q[2]; p3 <= q[3];
          a  <= 3 * (q[1] - q[2]) + q[3] - q[0];
          ph <= 2'd1;
        end
        2'd1: begin
          b  <= 2 * p0 - 5 * p1 + 4 * p2 - p3 + 32'(prod >>> 16);
          ph <= 2'd2;
        end
        2'd2: begin
          c  <= p2 - p0 + 32'(prod >>> 16);
          ph <= 2'd3;
        end
        default: begin
          ph <= 2'd0;
          if (cidx < 4'd12) begin
            rowv[cidx] <= res;
          end else begin
            pix[ch*8 +: 8] <= clamp8(res);
          end
          if (cidx == 4'd14) begin
            busy <= 1'b0;
          end
          cidx <= cidx + 4'd1;
        end
      endcase
    end
  end

endmodule

// File: design/bicubic_image_upscaler_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bicubic_image_upscaler_top
// Streaming Catmull-Rom upscaler with line stores in one synchronous RAM.
// ---------------------------------------------------------------------------
// An accepted request is read from the line RAM and then written back with
// the window shifted (ST_READ); a request that completes a window then runs
// the cubic unit once per output pixel, scale^2 times, each run waiting for a
// free output register. in_stall holds off new requests outside ST_IDLE.
// Reset (rst, synchronous): counters, window and registers to their reset
// values; the line RAM is not cleared.
module bicubic_image_upscaler_top #(
  parameter int MAX_WIDTH = biu_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_row,
  output logic [12:0] out_col,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import biu_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [3:0]  scale_factor;
  logic [10:0] image_width;
  logic [11:0] image_height;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= 4'd3;
      image_width  <= 11'd640;
      image_height <= 12'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCALE:  scale_factor <= cfg_data[3:0];
        REG_WIDTH:  image_width  <= cfg_data[10:0];
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective limits
  logic [3:0]  s;
  logic [13:0] w;
  logic [11:0] h;
  assign s = (scale_factor == 4'd0) ? 4'd1 :
             (scale_factor > 4'd8) ? 4'd8 : scale_factor;
  assign w = (image_width == 11'd0) ? 14'd1 :
             (14'(image_width) > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : 14'(image_width);
  assign h = (image_height == 12'd0) ? 12'd1 : image_height;

  // line RAM: three lines packed per column
  logic [71:0] lram [MAX_WIDTH];
  logic [71:0] lq;
  logic        lwe;
  logic [AW-1:0] laddr;
  logic [71:0] lwd;
  always_ff @(posedge clk) begin
    if (lwe) lram[laddr] <= lwd;
    lq <= lram[laddr];
  end

  biu_state_t state, state_next;
  logic [13:0] col;
  logic [11:0] row;
  logic [23:0] pin;
  logic [23:0] wnd [16];
  logic [16*24-1:0] wflat;
  logic [3:0]  sa, sb;
  logic        rd_ph;
  logic        run;
  logic        cstart, cdone;
  logic [23:0] cpix;
  logic        crun;

  assign laddr = AW'(col);
  assign lwd   = {pin, lq[71:24]};
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    for (int i = 0; i < 16; i++) wflat[i*24 +: 24] = wnd[i];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_READ;
      ST_READ: if (rd_ph) state_next = run ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (cdone && sa == s - 4'd1 && sb == s - 4'd1) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // A cubic run starts only when the output register is free or being
  // taken, so its result never lands on a waiting one.
  always_comb begin
    lwe    = (state == ST_READ) && rd_ph;
    cstart = (state == ST_EMIT) && !crun && (!out_valid || !out_stall);
  end

  assign run = (row >= 12'd3) && (col >= 14'd3);

  // cubic unit in flight: from start until its done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      crun <= 1'b0;
    end else if (cstart) begin
      crun <= 1'b1;
    end else if (cdone) begin
      crun <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
      row   <= '0;
      rd_ph <= 1'b0;
      sa    <= '0;
      sb    <= '0;
      for (int i = 0; i < 16; i++) wnd[i] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid) begin
        pin   <= {in_red, in_green, in_blue};
        rd_ph <= 1'b0;
      end
      if (state == ST_READ) begin
        rd_ph <= 1'b1;
        if (rd_ph) begin
          for (int l = 0; l < 4; l++) begin
            for (int k = 0; k < 3; k++) wnd[l*4+k] <= wnd[l*4+k+1];
          end
          wnd[3]  <= lq[23:0];
          wnd[7]  <= lq[47:24];
          wnd[11] <= lq[71:48];
          wnd[15] <= pin;
          sa <= '0;
          sb <= '0;
          if (!run) begin
            if (col + 14'd1 >= w) begin
              col <= '0;
              row <= (row + 12'd1 >= h) ? 12'd0 : row + 12'd1;
            end else begin
              col <= col + 14'd1;
            end
          end
        end
      end
      if (state == ST_EMIT && cdone) begin
        if (sb == s - 4'd1) begin
          sb <= '0;
          sa <= sa + 4'd1;
        end else begin
          sb <= sb + 4'd1;
        end
        if (sa == s - 4'd1 && sb == s - 4'd1) begin
          if (col + 14'd1 >= w) begin
            col <= '0;
            row <= (row + 12'd1 >= h) ? 12'd0 : row + 12'd1;
          end else begin
            col <= col + 14'd1;
          end
        end
      end
    end
  end

  biu_cubic u_cubic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .win   (wflat),
    .tcol  (frac_q16(sb, s)),
    .trow  (frac_q16(sa, s)),
    .done  (cdone),
    .pix   (cpix)
  );

  // output register; cubic unit is idle while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cdone) begin
      out_valid   <= 1'b1;
      out_row     <= 15'(19'(s) * 19'(row - 12'd3) + 19'(sa));
      out_col     <= 13'(18'(s) * 18'(col - 14'd3) + 18'(sb));
      out_blue    <= cpix[7:0];
      out_green   <= cpix[15:8];
      out_red     <= cpix[23:16];
      last_of_run <= (sa == s - 4'd1) && (sb == s - 4'd1);
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: design/biu_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biu_checker
// Port-level checks of the upscaler.
// ---------------------------------------------------------------------------
module biu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_blue,
  input logic        last_of_run
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_blue))
    else $error("output changed while stalled");
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after request");
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(last_of_run))
    else $error("last flag changed while stalled");
endmodule

bind bicubic_image_upscaler_top biu_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_blue(out_blue),
  .last_of_run(last_of_run)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for bicubic_image_upscaler_top: source frames go in as
// raster pixel requests, and every output pixel is checked against a
// fixed-point Catmull-Rom predictor that runs beside the design.
// ---------------------------------------------------------------------------
module testbench;
  import biu_pkg::*;

  localparam int LW = 1024;            // line length of each line store
  localparam int LIMIT = 3000000;      // cycle guard for the whole run

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } src_pix_t;

  typedef struct {
    logic [14:0] row;
    logic [12:0] col;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        last;
  } up_pix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_blue = '0;
  logic [7:0]  in_green = '0;
  logic [7:0]  in_red = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] out_row;
  logic [12:0] out_col;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic        last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  // Stimulus and expectations
  src_pix_t source_pixels[$];
  up_pix_t  expected_pixels[$];
  int       errors = 0;
  int       cycles = 0;
  int       send_gap_pct = 0;
  int       recv_stall_pct = 0;
  bit       drain_hold = 1'b0;

  // Mirror of the design state
  logic [23:0] lines[0:3*LW-1];
  logic [23:0] win[4][4];
  int          col_cnt;
  int          row_cnt;
  logic [3:0]  scale_reg;
  logic [10:0] width_reg;
  logic [11:0] height_reg;

  bicubic_image_upscaler_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row(out_row), .out_col(out_col),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
    .last_of_run(last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Registers as the design sees them: zero scale is 1, big scale saturates,
  // zero width is 1, wide is clamped to the line length, zero height is 1.
  function automatic void eff_dims(output int s, output int w, output int h);
    s = (scale_reg == 0) ? 1 : ((scale_reg > 8) ? 8 : int'(scale_reg));
    w = (width_reg == 0) ? 1 : ((width_reg > LW) ? LW : int'(width_reg));
    h = (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  // One Catmull-Rom segment; arithmetic shifts round toward minus infinity.
  function automatic longint catmull(longint p0, longint p1, longint p2, longint p3,
                                     longint t);
    longint a, b, c;
    a = 3 * (p1 - p2) + p3 - p0;
    b = 2 * p0 - 5 * p1 + 4 * p2 - p3 + ((t * a) >>> 16);
    c = p2 - p0 + ((t * b) >>> 16);
    return p1 + ((t * c) >>> 17);
  endfunction

  // Columns first for each window row, then down the rows.
  function automatic logic [7:0] interp_channel(int sh, longint trow, longint tcol);
    longint rv[4];
    longint p[4];
    longint v;
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < 4; k++)
        p[k] = longint'((win[l][k] >> sh) & 24'hff) <<< 16;
      rv[l] = catmull(p[0], p[1], p[2], p[3], tcol);
    end
    v = catmull(rv[0], rv[1], rv[2], rv[3], trow);
    if (v <= 0) return 8'd0;
    v = v >>> 16;
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // Shifts one source pixel through line stores and window; queues the
  // output pixels that it completes.
  function automatic void upscale_pixel(logic [7:0] b8, logic [7:0] g8, logic [7:0] r8);
    logic [23:0] colv[4];
    int s, w, h;
    longint trow, tcol;
    up_pix_t o;
    eff_dims(s, w, h);
    colv[0] = lines[col_cnt];
    colv[1] = lines[LW + col_cnt];
    colv[2] = lines[2*LW + col_cnt];
    colv[3] = {r8, g8, b8};
    lines[col_cnt] = colv[1];
    lines[LW + col_cnt] = colv[2];
    lines[2*LW + col_cnt] = colv[3];
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < 3; k++)
        win[l][k] = win[l][k+1];
      win[l][3] = colv[l];
    end
    if (row_cnt >= 3 && col_cnt >= 3) begin
      for (int a = 0; a < s; a++) begin
        trow = ((longint'(a) <<< 16) + s / 2) / s;
        for (int bb = 0; bb < s; bb++) begin
          tcol = ((longint'(bb) <<< 16) + s / 2) / s;
          o.row   = 15'(s * (row_cnt - 3) + a);
          o.col   = 13'(s * (col_cnt - 3) + bb);
          o.blue  = interp_channel(0, trow, tcol);
          o.green = interp_channel(8, trow, tcol);
          o.red   = interp_channel(16, trow, tcol);
          o.last  = (a == s - 1) && (bb == s - 1);
          expected_pixels.push_back(o);
        end
      end
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Request driver; the mirror advances on each accepted request.
  always @(posedge clk) begin : src_drv
    src_pix_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) upscale_pixel(in_blue, in_green, in_red);
      if (!in_valid || !in_stall) begin
        // drain hold: no new request while output pixels are still owed
        if (source_pixels.size() != 0 && $urandom_range(99) >= send_gap_pct &&
            !(drain_hold && expected_pixels.size() != 0)) begin
          p = source_pixels.pop_front();
          in_valid <= 1'b1;
          in_blue  <= p.blue;
          in_green <= p.green;
          in_red   <= p.red;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and random back-pressure.
  always @(posedge clk) begin : out_mon
    up_pix_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch("output pixel with none owed, row", out_row, -1);
        end else begin
          want = expected_pixels.pop_front();
          if (out_row != want.row) note_mismatch("out_row", out_row, want.row);
          if (out_col != want.col) note_mismatch("out_col", out_col, want.col);
          if (out_blue != want.blue) note_mismatch("out_blue", out_blue, want.blue);
          if (out_green != want.green) note_mismatch("out_green", out_green, want.green);
          if (out_red != want.red) note_mismatch("out_red", out_red, want.red);
          if (last_of_run != want.last) note_mismatch("last_of_run", last_of_run, want.last);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("bicubic_image_upscaler_top regression: fail");
      $finish;
    end
  end

  // Idle: nothing queued, nothing in flight, nothing owed, plus a wait to let
  // a request that completes no window finish.
  task automatic wait_idle();
    do @(negedge clk);
    while (source_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [11:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk);
    while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCALE:  scale_reg  = val[3:0];
      REG_WIDTH:  width_reg  = val[10:0];
      REG_HEIGHT: height_reg = val[11:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_cfg(int s, int w, int h);
    cfg_write(REG_SCALE, 12'(s));
    cfg_write(REG_WIDTH, 12'(w));
    cfg_write(REG_HEIGHT, 12'(h));
  endtask

  // pattern: 0 random, 1 checkerboard (overshoot both ways), 2 white, 3 black
  task automatic feed(int n, int pattern, int w);
    src_pix_t p;
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      v = (((i % w) + (i / w)) % 2) ? 8'd255 : 8'd0;
      case (pattern)
        1: p = '{blue: v, green: ~v, red: v};
        2: p = '{blue: 8'd255, green: 8'd255, red: 8'd255};
        3: p = '{blue: 8'd0, green: 8'd0, red: 8'd0};
        default: p = '{blue: 8'($urandom), green: 8'($urandom), red: 8'($urandom)};
      endcase
      source_pixels.push_back(p);
    end
  endtask

  // Finish the current frame under the current registers so that the next
  // one starts at column 0 of row 0.
  task automatic align_frame();
    int s, w, h, c, r, n;
    wait_idle();
    eff_dims(s, w, h);
    c = col_cnt;
    r = row_cnt;
    n = 0;
    while (c != 0 || r != 0) begin
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c++;
      end
      n++;
    end
    feed(n, 0, 4);
    wait_idle();
  endtask

  task automatic run_frame(int s, int w, int h, int pattern);
    align_frame();
    set_cfg(s, w, h);
    feed(w * h, pattern, w);
  endtask

  task automatic random_phase(int gap, int stall, int n_items);
    int s, w, h, sent;
    wait_idle();
    send_gap_pct = gap;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        s = $urandom_range(4, 8);
        w = 4;
        h = 4;
      end else begin
        s = $urandom_range(1, 3);
        w = $urandom_range(4, 8);
        h = $urandom_range(4, 6);
      end
      run_frame(s, w, h, ($urandom_range(9) == 0) ? 1 : 0);
      sent += w * h;
    end
  endtask

  initial begin
    for (int i = 0; i < 3 * LW; i++) lines[i] = '0;
    for (int l = 0; l < 4; l++)
      for (int k = 0; k < 4; k++) win[l][k] = '0;
    col_cnt = 0;
    row_cnt = 0;
    scale_reg = 4'd3;
    width_reg = 11'd640;
    height_reg = 12'd480;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: value extremes and clamping at both ends
    run_frame(4, 4, 4, 1);
    run_frame(2, 4, 4, 3);
    run_frame(1, 4, 4, 2);
    // zero scale acts as 1, scale above the maximum saturates
    run_frame(0, 4, 4, 0);
    run_frame(15, 4, 4, 1);
    // wide and tall register extremes; shrink back before realigning
    align_frame();
    set_cfg(1, 2047, 4095);
    feed(8, 0, 4);
    wait_idle();
    cfg_write(REG_HEIGHT, 12'd4);
    cfg_write(REG_WIDTH, 12'd4);
    // zero width and height act as 1: every pixel wraps, no window
    align_frame();
    set_cfg(0, 0, 0);
    feed(5, 0, 4);
    // narrow frames never complete a window
    run_frame(2, 3, 5, 0);
    run_frame(2, 4, 3, 0);
    // shrink registers mid-frame: counters past the limit wrap
    run_frame(2, 8, 6, 0);
    wait_idle();
    source_pixels.delete();
    align_frame();
    set_cfg(2, 8, 6);
    feed(37, 0, 8);
    wait_idle();
    cfg_write(REG_HEIGHT, 12'd4);
    feed(3, 0, 8);
    wait_idle();
    cfg_write(REG_WIDTH, 12'd5);
    feed(12, 0, 5);

    // Random frames under each idling mix
    random_phase(0, 0, 15);
    random_phase(48, 0, 15);
    random_phase(0, 48, 15);
    random_phase(19, 19, 15);
    // sender holds off until every owed output pixel has come
    wait_idle();
    drain_hold = 1'b1;
    random_phase(0, 30, 15);
    wait_idle();
    drain_hold = 1'b0;

    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("bicubic_image_upscaler_top regression: pass");
    end else begin
      $display("bicubic_image_upscaler_top regression: fail");
    end
    $finish;
  end

endmodule

// File: bicubic_image_upscaler_top.f
design/biu_pkg.sv
design/biu_cubic.sv
design/bicubic_image_upscaler_top.sv
design/biu_checker.sv
test/testbench.sv
